### rtl/lfucl_pkg.sv
package lfucl_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_BITS  = IDX_BITS;
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam int S_TDATA_BITS = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 + VALUE_BITS + KEY_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_HIT,
        CMD_INSERT
    } cmd_op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cmd_op_t                 op;
        logic                    is_put;
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   data;
        logic [IDX_BITS-1:0]     hit_idx;
        logic [RANK_BITS-1:0]    hit_rank;
        logic                    evict;
        logic [IDX_BITS-1:0]     vic_idx;
        logic [RANK_BITS-1:0]    vic_rank;
        logic [IDX_BITS-1:0]     ins_idx;
    } cmd_t;

    // token handed from cell to cell during a victim scan
    typedef struct packed {
        logic                    go;
        logic                    have;
        logic [COUNT_BITS-1:0]   cnt;
        logic [RANK_BITS-1:0]    rank;
        logic [IDX_BITS-1:0]     idx;
        logic [KEY_BITS-1:0]     key;
        logic                    free_have;
        logic [IDX_BITS-1:0]     free_idx;
    } scan_t;

    // what a cell shows for lookup
    typedef struct packed {
        logic                    match;
        logic [VALUE_BITS-1:0]   data;
        logic [RANK_BITS-1:0]    rank;
    } peek_t;

endpackage

### rtl/lfu_cache_lru_tiebreak_unit.sv
// LFU cache with LRU tie break over a row of ENTRIES cells, each holding one
// key, value, saturating use count and recency rank. A request is taken in one
// beat and handled alone: a get, a put hit or a disabled cache (capacity 0) is
// looked up in ST_LOOK, which registers its result as it returns to ST_IDLE
// for the next request. A put miss scans the row for the least-used, oldest
// victim and a free slot by passing a token through the cells one per cycle
// in ST_SCAN; ST_FIN then writes the entry and registers the result. The
// result waits in an output register, and the next request may be taken
// while it does; a stalled result holds back the next one. Capacity is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while
// idle, not enforced by the block. Values above ENTRIES act as ENTRIES.
module lfu_cache_lru_tiebreak_unit
    import lfucl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CAP_BITS-1:0]     cfg_wr_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [31:0] key, [63:32] write_value
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    // [0] req_type
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [0] hit, [32:1] read_value, [33] evicted, [65:34] evicted_key
    output logic [M_TDATA_BITS-1:0] m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t                state_reg, state_next;
    logic                  put_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CAP_BITS-1:0]   cap_reg;
    logic [OCC_BITS-1:0]   occ_reg, occ_next;
    scan_t                 vic_reg;
    logic                  mv_reg, mv_next;
    logic [M_FIELD_BITS-1:0] mres_reg, mres_next;

    cmd_t                  cmd;
    scan_t                 chain [ENTRIES+1];
    peek_t                 peeks [ENTRIES];
    logic                  any_hit;
    logic [VALUE_BITS-1:0] hit_data;
    logic [RANK_BITS-1:0]  hit_rank;
    logic [IDX_BITS-1:0]   hit_idx;
    logic [CAP_BITS-1:0]   cap_eff;
    logic                  out_free;
    logic                  full;
    logic                  start;
    logic [IDX_BITS-1:0]   ins_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = M_TDATA_BITS'(mres_reg);
    assign out_free = !mv_reg || m_tready;
    assign cap_eff  = (cap_reg > CAP_BITS'(ENTRIES)) ? CAP_BITS'(ENTRIES) : cap_reg;
    assign full     = (OCC_BITS + 1)'(occ_reg) >= (OCC_BITS + 1)'(cap_eff);

    // cell row
    always_comb begin
        chain[0]    = '0;
        chain[0].go = start;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfucl_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_BITS'(g)),
            .look_key (key_reg),
            .cmd      (cmd),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1]),
            .peek     (peeks[g])
        );
    end

    // lookup: keys are unique, so an OR over the matching cell suffices
    always_comb begin
        any_hit  = 1'b0;
        hit_data = '0;
        hit_rank = '0;
        hit_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (peeks[i].match) begin
                any_hit  = 1'b1;
                hit_data = hit_data | peeks[i].data;
                hit_rank = hit_rank | peeks[i].rank;
                hit_idx  = hit_idx | IDX_BITS'(i);
            end
        end
    end

    // insert slot: the first free cell; on eviction the lower of it and the victim
    always_comb begin
        if (vic_reg.free_have && !(full && (vic_reg.idx < vic_reg.free_idx)))
            ins_idx = vic_reg.free_idx;
        else
            ins_idx = vic_reg.idx;
    end

    // control
    always_comb begin
        state_next = state_reg;
        occ_next   = occ_reg;
        mv_next    = mv_reg && !m_tready;
        mres_next  = mres_reg;
        start      = 1'b0;
        cmd        = '0;
        cmd.op     = CMD_NONE;
        cmd.is_put = put_reg;
        cmd.key    = key_reg;
        cmd.data   = val_reg;
        cmd.hit_idx  = hit_idx;
        cmd.hit_rank = hit_rank;
        cmd.evict    = full;
        cmd.vic_idx  = vic_reg.idx;
        cmd.vic_rank = vic_reg.rank;
        cmd.ins_idx  = ins_idx;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                if ((cap_eff != '0) && !any_hit && put_reg) begin
                    start      = 1'b1;
                    state_next = ST_SCAN;
                end else if (out_free) begin
                    mv_next   = 1'b1;
                    mres_next = '0;
                    if ((cap_eff != '0) && any_hit) begin
                        cmd.op       = CMD_HIT;
                        mres_next[0] = 1'b1;
                        if (!put_reg) mres_next[VALUE_BITS:1] = hit_data;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (chain[ENTRIES].go) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.op    = CMD_INSERT;
                    mv_next   = 1'b1;
                    mres_next = '0;
                    if (full) begin
                        mres_next[VALUE_BITS+1] = 1'b1;
                        mres_next[M_FIELD_BITS-1:VALUE_BITS+2] = vic_reg.key;
                    end else begin
                        occ_next = occ_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            cap_reg   <= CAP_RESET;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            mv_reg    <= mv_next;
            if (cfg_wr_en) cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        mres_reg <= mres_next;
        if (s_tvalid && s_tready) begin
            put_reg <= s_tuser;
            key_reg <= s_tdata[KEY_BITS-1:0];
            val_reg <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
        end
        if (state_reg == ST_SCAN && chain[ENTRIES].go) vic_reg <= chain[ENTRIES];
    end

endmodule

### rtl/lfucl_cell.sv
module lfucl_cell
    import lfucl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IDX_BITS-1:0]   cell_idx,
    input  logic [KEY_BITS-1:0]   look_key,
    input  cmd_t                  cmd,
    input  scan_t                 scan_in,
    output scan_t                 scan_out,
    output peek_t                 peek
);

    logic                  valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] data_reg, data_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [RANK_BITS-1:0]  rank_reg, rank_next;
    scan_t                 scan_reg, scan_next;
    logic                  take;

    // lookup view
    assign peek.match = valid_reg && (key_reg == look_key);
    assign peek.data  = data_reg;
    assign peek.rank  = rank_reg;

    // scan stage: keep the lower count, older entry on a tie; note the first free cell
    always_comb begin
        take = valid_reg && (!scan_in.have || (cnt_reg < scan_in.cnt) ||
               ((cnt_reg == scan_in.cnt) && (rank_reg > scan_in.rank)));
        scan_next = scan_in;
        if (take) begin
            scan_next.have = 1'b1;
            scan_next.cnt  = cnt_reg;
            scan_next.rank = rank_reg;
            scan_next.idx  = cell_idx;
            scan_next.key  = key_reg;
        end
        if (!valid_reg && !scan_in.free_have) begin
            scan_next.free_have = 1'b1;
            scan_next.free_idx  = cell_idx;
        end
    end

    assign scan_out = scan_reg;

    // entry update
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        rank_next  = rank_reg;
        case (cmd.op)
            CMD_HIT: begin
                if (cell_idx == cmd.hit_idx) begin
                    if (cmd.is_put) data_next = cmd.data;
                    if (cnt_reg != COUNT_MAX) cnt_next = cnt_reg + 1'b1;
                    rank_next = '0;
                end else if (valid_reg && (rank_reg < cmd.hit_rank)) begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            CMD_INSERT: begin
                if (cell_idx == cmd.ins_idx) begin
                    valid_next = 1'b1;
                    key_next   = cmd.key;
                    data_next  = cmd.data;
                    cnt_next   = COUNT_BITS'(1);
                    rank_next  = '0;
                end else if (cmd.evict && (cell_idx == cmd.vic_idx)) begin
                    valid_next = 1'b0;
                end else if (valid_reg) begin
                    // age by one, less one if older than the victim
                    if (cmd.evict && (rank_reg > cmd.vic_rank)) rank_next = rank_reg;
                    else rank_next = rank_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            scan_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
        cnt_reg  <= cnt_next;
        rank_reg <= rank_next;
    end

endmodule

### rtl/lfucl_checker.sv
module lfucl_checker
    import lfucl_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // an eviction only comes from a miss
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[VALUE_BITS+1]))
        else $error("eviction on a hit");

    // a nonzero read value needs a hit
    a_read_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[VALUE_BITS:1] != '0) |-> m_tdata[0])
        else $error("read value without hit");

    // evicted key is zero without an eviction
    a_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[VALUE_BITS+1] |->
            (m_tdata[M_FIELD_BITS-1:VALUE_BITS+2] == '0))
        else $error("stray evicted key");

endmodule

bind lfu_cache_lru_tiebreak_unit lfucl_checker u_lfucl_checker (.*);
